### design/hbwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbwl_pkg
// Shared types and constants for the hex/binary text word loader.
// ----------------------------------------------------------------------------
package hbwl_pkg;

    localparam int WORD_W      = 64;
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // input function codes
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_EOS  = 1'b1;

    // radix modes
    localparam logic RADIX_HEX = 1'b0;
    localparam logic RADIX_BIN = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;
    localparam logic [3:0]        DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic [WORD_W-1:0] acc;
        logic              token;
        logic              in_comment;
        logic              bad;
        logic              stopped;
    } parse_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_value;
        logic [KIND_W-1:0] kind;
        logic              last;
    } result_t;

    // up to two results per item; v1 implies v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

### design/hbwl_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbwl_parse
// Per-character parser step: next state and up to two results.
// ----------------------------------------------------------------------------
module hbwl_parse (
    input  hbwl_pkg::parse_state_t       cur,
    input  logic                         radix_mode,
    input  logic                         func,
    input  logic [hbwl_pkg::CHAR_W-1:0]  char_code,
    output hbwl_pkg::parse_state_t       nxt,
    output hbwl_pkg::push_t              push
);
    import hbwl_pkg::*;

    logic          is_dec;
    logic          is_uhex;
    logic          is_lhex;
    logic          is_digit;
    logic [3:0]    digit;
    logic          is_eol;
    logic          is_blank;
    result_t       tok_res;
    result_t       end_res;

    always_comb begin
        is_dec   = (char_code >= CH_0)  && (char_code <= CH_9);
        is_uhex  = (char_code >= CH_UA) && (char_code <= CH_UF);
        is_lhex  = (char_code >= CH_LA) && (char_code <= CH_LF_HEX);
        is_digit = is_dec || is_uhex || is_lhex;
        is_eol   = (char_code == CH_CR) || (char_code == CH_LF);
        is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
        priority if (is_dec) begin
            digit = 4'(char_code - CH_0);
        end else if (is_uhex) begin
            digit = 4'(char_code - CH_UA) + DIGIT_TEN;
        end else begin
            digit = 4'(char_code - CH_LA) + DIGIT_TEN;
        end

        tok_res.word_value = cur.bad ? '0 : cur.acc;
        tok_res.kind       = cur.bad ? KIND_ERROR : KIND_WORD;
        tok_res.last       = 1'b1;
        end_res.word_value = '0;
        end_res.kind       = KIND_END;
        end_res.last       = 1'b1;

        nxt     = cur;
        push.v0 = 1'b0;
        push.v1 = 1'b0;
        push.r0 = tok_res;
        push.r1 = end_res;

        if (!cur.stopped) begin
            if (func == FUNC_EOS) begin
                // flush pending token, then end marker unless it was an error
                push.v0        = 1'b1;
                push.r0        = cur.token ? tok_res : end_res;
                push.v1        = cur.token && !cur.bad;
                push.r0.last   = !(cur.token && !cur.bad);
                nxt.acc        = '0;
                nxt.token      = 1'b0;
                nxt.bad        = 1'b0;
                nxt.in_comment = 1'b0;
                nxt.stopped    = 1'b1;
            end else if (cur.in_comment) begin
                if (is_eol) begin
                    nxt.in_comment = 1'b0;
                end
            end else if (is_blank) begin
                nxt = cur;
            end else if (is_eol || (char_code == CH_HASH) || !is_digit) begin
                if (char_code == CH_HASH) begin
                    nxt.in_comment = 1'b1;
                end
                if (cur.token) begin
                    // close the token
                    push.v0     = 1'b1;
                    nxt.acc     = '0;
                    nxt.token   = 1'b0;
                    nxt.bad     = 1'b0;
                    nxt.stopped = cur.bad;
                end else if (!is_eol && (char_code != CH_HASH)) begin
                    // stray character with no token: end of load
                    push.v0     = 1'b1;
                    push.r0     = end_res;
                    nxt.stopped = 1'b1;
                end
            end else begin
                nxt.token = 1'b1;
                if (radix_mode == RADIX_HEX) begin
                    nxt.acc = {cur.acc[WORD_W-5:0], digit};
                end else if (digit <= 4'd1) begin
                    nxt.acc = {cur.acc[WORD_W-2:0], digit[0]};
                end else begin
                    nxt.bad = 1'b1;
                end
            end
        end
    end

endmodule

### design/hbwl_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbwl_outq
// Small result queue: takes up to two results a cycle, drains one while out_ready is high.
// ----------------------------------------------------------------------------
module hbwl_outq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hbwl_pkg::push_t               push,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hbwl_pkg::result_t             out_res
);
    import hbwl_pkg::*;

    result_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QPTR_W-1:0]   wr_ptr_p1;
    logic                pop;
    logic [QCNT_W-1:0]   push_n;

    always_comb begin
        pop         = out_valid && out_ready;
        push_n      = QCNT_W'(push.v0) + QCNT_W'(push.v1);
        wr_ptr_p1   = wr_ptr_reg + QPTR_W'(1);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + push_n - QCNT_W'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    // keep space for the worst case of two results from one item
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/hex_or_binary_text_word_loader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_or_binary_text_word_loader_core
// Parses a text character stream into 64-bit words in hex or binary radix.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per character: s_tdata is the character byte,
//   s_tuser is 1 for end of stream. m_* carries result items: m_tdata is the
//   64-bit word, m_tuser the kind (0 word, 1 end of load, 2 error), m_tlast
//   marks the final result caused by one input item.
//   cfg_wr_en/cfg_wr_data set the radix (0 hex, 1 binary); write it only
//   while the block is idle.
// Timing:
//   Each accepted item updates the registered parser state and writes its
//   results into a four-entry result queue feeding m_*. Throughput is one
//   item per cycle while s_tready is high, set by the combinational step.
// Reset:
//   aresetn (synchronous, active low) clears the parser state, the radix
//   and the queue. After an end marker or an error all input is taken and
//   dropped until the next reset.
// Stalls:
//   When m_tready is low, results collect in the queue; s_tready drops once
//   fewer than two free entries remain.
// ----------------------------------------------------------------------------
module hex_or_binary_text_word_loader_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_code
    input  logic                          s_tuser,   // [0] func
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // [63:0] word_value
    output logic [1:0]                    m_tuser,   // [1:0] kind
    output logic                          m_tlast,   // last result of an item
    // configuration
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data  // radix_mode
);
    import hbwl_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_state_t  step_state;
    logic          radix_reg;
    push_t         step_push;
    push_t         push;
    logic          accept;
    logic          room;
    result_t       head;

    // Evaluate the parser step on the offered character.
    hbwl_parse u_parse (
        .cur        (state_reg),
        .radix_mode (radix_reg),
        .func       (s_tuser),
        .char_code  (s_tdata),
        .nxt        (step_state),
        .push       (step_push)
    );

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    // Commit state and results only for an accepted item.
    always_comb begin
        state_next = accept ? step_state : state_reg;
        push       = step_push;
        push.v0    = accept && step_push.v0;
        push.v1    = accept && step_push.v1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            radix_reg <= RADIX_HEX;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                radix_reg <= cfg_wr_data;
            end
        end
    end

    // Hold results until the receiver takes them.
    hbwl_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata = head.word_value;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
